FILE: rtl/core/pds_pkg.sv
// Shared types, constants and widths for the PLL divider search block.
`timescale 1ns / 1ps
package pds_pkg;

  // Search limits: m runs 2..FEEDBACK_LIMIT-1, n runs 2..INPUT_DIV_LIMIT-1.
  localparam int unsigned FEEDBACK_LIMIT  = 256;
  localparam int unsigned INPUT_DIV_LIMIT = 32;

  localparam int unsigned M_W  = $clog2(FEEDBACK_LIMIT);
  localparam int unsigned N_W  = $clog2(INPUT_DIV_LIMIT);
  localparam int unsigned OD_W = 2;

  localparam logic [M_W-1:0]  M_FIRST = M_W'(2);
  localparam logic [M_W-1:0]  M_LAST  = M_W'(FEEDBACK_LIMIT - 1);
  localparam logic [N_W-1:0]  N_FIRST = N_W'(2);
  localparam logic [N_W-1:0]  N_LAST  = N_W'(INPUT_DIV_LIMIT - 1);
  localparam logic [OD_W-1:0] OD_LAST = OD_W'(3);

  // Field widths.
  localparam int unsigned REF_W  = 8;
  localparam int unsigned TOL_W  = 10;
  localparam int unsigned VCO_W  = 12;
  localparam int unsigned TGT_W  = 14;
  localparam int unsigned WORD_W = 16;

  // Packing of the divider word.
  localparam int unsigned WORD_N_LSB  = 9;
  localparam int unsigned WORD_OD_LSB = 14;

  // Reference divided by n must stay at or below this many MHz.
  localparam int unsigned REF_RATIO_MAX = 25;
  localparam int unsigned RATIO_W = N_W + $clog2(REF_RATIO_MAX + 1);

  // Datapath widths of the running products.
  localparam int unsigned LO_W    = TGT_W;
  localparam int unsigned HI_W    = TGT_W + 1;
  localparam int unsigned REFM_W  = REF_W + M_W;
  localparam int unsigned FOUT_W  = REFM_W + 4;
  localparam int unsigned LON_W   = LO_W + N_W;
  localparam int unsigned HIN_W   = HI_W + N_W;
  localparam int unsigned VN_W    = VCO_W + N_W;
  localparam int unsigned CMP_W   = HIN_W + 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = VCO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_FREQ = 3'd0,
    CFG_TOL      = 3'd1,
    CFG_VCO_MIN  = 3'd2,
    CFG_VCO_MAX  = 3'd3
  } cfg_idx_e;

  localparam logic [REF_W-1:0] REF_RESET     = REF_W'(27);
  localparam logic [TOL_W-1:0] TOL_RESET     = TOL_W'(32);
  localparam logic [VCO_W-1:0] VCO_MIN_RESET = VCO_W'(200);
  localparam logic [VCO_W-1:0] VCO_MAX_RESET = VCO_W'(1000);

  typedef struct packed {
    logic [REF_W-1:0] ref_freq;
    logic [TOL_W-1:0] tol;
    logic [VCO_W-1:0] vco_min;
    logic [VCO_W-1:0] vco_max;
  } cfg_t;

  // One candidate as seen by the evaluation unit.
  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [OD_W-1:0]   od;
    logic [REFM_W-1:0] ref_m;
    logic [LON_W-1:0]  lo_n;
    logic [HIN_W-1:0]  hi_n;
    logic [VN_W-1:0]   vmin_n;
    logic [VN_W-1:0]   vmax_n;
  } cand_t;

  typedef struct packed {
    logic n_ok;
    logic pass;
  } eval_t;

endpackage

FILE: rtl/core/pds_if.sv
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps
interface pds_req_if
  import pds_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_freq_q4;

  modport source (output valid, output target_freq_q4, input ready);
  modport sink   (input valid, input target_freq_q4, output ready);
endinterface

interface pds_rsp_if
  import pds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              found;
  logic [WORD_W-1:0] divider_word;

  modport source (output valid, output found, output divider_word, input ready);
  modport sink   (input valid, input found, input divider_word, output ready);
endinterface

interface pds_cfg_if
  import pds_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pds_cfg_regs.sv
// Configuration register file for the PLL divider search.
`timescale 1ns / 1ps
module pds_cfg_regs
  import pds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; indexes beyond the list leave every register alone.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CFG_REF_FREQ: cfg_d.ref_freq = wr_data_i[REF_W-1:0];
        CFG_TOL:      cfg_d.tol      = wr_data_i[TOL_W-1:0];
        CFG_VCO_MIN:  cfg_d.vco_min  = wr_data_i[VCO_W-1:0];
        CFG_VCO_MAX:  cfg_d.vco_max  = wr_data_i[VCO_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_freq <= REF_RESET;
      cfg_q.tol      <= TOL_RESET;
      cfg_q.vco_min  <= VCO_MIN_RESET;
      cfg_q.vco_max  <= VCO_MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/pds_eval.sv
// Candidate evaluation unit: checks one (m, n, od) against all limits.
`timescale 1ns / 1ps
module pds_eval
  import pds_pkg::*;
(
  input  logic [REF_W-1:0] ref_freq_i,
  input  cand_t            cand_i,
  output eval_t            eval_o
);

  logic [RATIO_W-1:0] n_ratio;
  logic [FOUT_W-1:0]  fout;
  logic [CMP_W-1:0]   lo_bound;
  logic [CMP_W-1:0]   hi_bound;
  logic               ref_ok;
  logic               fout_ok;
  logic               vco_ok;

  // The reference divided by n must lie within 1 .. REF_RATIO_MAX MHz.
  assign n_ratio = RATIO_W'(cand_i.n) * RATIO_W'(REF_RATIO_MAX);
  assign ref_ok  = (ref_freq_i >= REF_W'(cand_i.n)) &&
                   (RATIO_W'(ref_freq_i) <= n_ratio);

  // Output frequency: 16*ref*m compared with the bounds times n*2^od.
  assign fout     = {cand_i.ref_m, 4'b0000};
  assign lo_bound = CMP_W'(cand_i.lo_n) << cand_i.od;
  assign hi_bound = CMP_W'(cand_i.hi_n) << cand_i.od;
  assign fout_ok  = (CMP_W'(fout) > lo_bound) && (CMP_W'(fout) < hi_bound);

  // VCO frequency: ref*m strictly between the limits times n.
  assign vco_ok = (VN_W'(cand_i.ref_m) > cand_i.vmin_n) &&
                  (VN_W'(cand_i.ref_m) < cand_i.vmax_n);

  assign eval_o.n_ok = ref_ok;
  assign eval_o.pass = ref_ok && fout_ok && vco_ok;

endmodule

FILE: rtl/core/pds_seq.sv
// Search sequencer: walks m, n and od and keeps the running products.
`timescale 1ns / 1ps
module pds_seq
  import pds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              start_i,
  input  logic [TGT_W-1:0]  target_i,
  output logic              idle_o,
  output cand_t             cand_o,
  input  eval_t             eval_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              found_o,
  output logic [WORD_W-1:0] word_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [M_W-1:0]    m_q, m_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [OD_W-1:0]   od_q, od_d;
  logic [REFM_W-1:0] refm_q, refm_d;
  logic [LON_W-1:0]  lon_q, lon_d;
  logic [HIN_W-1:0]  hin_q, hin_d;
  logic [VN_W-1:0]   vminn_q, vminn_d;
  logic [VN_W-1:0]   vmaxn_q, vmaxn_d;
  logic [LO_W-1:0]   lo_q, lo_d;
  logic [HI_W-1:0]   hi_q, hi_d;
  logic              found_q, found_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic [LO_W-1:0]   start_lo;
  logic [HI_W-1:0]   start_hi;
  logic              next_n;
  logic [WORD_W-1:0] hit_word;

  // Bounds for a new request; a negative lower bound clamps to zero.
  assign start_lo = (target_i >= TGT_W'(cfg_i.tol)) ?
                    LO_W'(target_i - TGT_W'(cfg_i.tol)) : '0;
  assign start_hi = HI_W'(target_i) + HI_W'(cfg_i.tol);

  // A failing n skips its remaining post dividers at once.
  assign next_n = !eval_i.n_ok || (od_q == OD_LAST);

  // Packed result for the current candidate.
  always_comb begin
    hit_word = '0;
    hit_word[M_W-1:0]                = m_q;
    hit_word[WORD_N_LSB +: N_W]      = n_q;
    hit_word[WORD_OD_LSB +: OD_W]    = od_q;
  end

  // Sequencer and running products.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    n_d     = n_q;
    od_d    = od_q;
    refm_d  = refm_q;
    lon_d   = lon_q;
    hin_d   = hin_q;
    vminn_d = vminn_q;
    vmaxn_d = vmaxn_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    found_d = found_q;
    word_d  = word_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SEARCH;
          m_d     = M_FIRST;
          n_d     = N_FIRST;
          od_d    = '0;
          lo_d    = start_lo;
          hi_d    = start_hi;
          refm_d  = REFM_W'(cfg_i.ref_freq) << 1;
          lon_d   = LON_W'(start_lo) << 1;
          hin_d   = HIN_W'(start_hi) << 1;
          vminn_d = VN_W'(cfg_i.vco_min) << 1;
          vmaxn_d = VN_W'(cfg_i.vco_max) << 1;
        end
      end

      ST_SEARCH: begin
        if (eval_i.pass) begin
          state_d = ST_DONE;
          found_d = 1'b1;
          word_d  = hit_word;
        end else if (!next_n) begin
          od_d = od_q + OD_W'(1);
        end else if (n_q != N_LAST) begin
          n_d     = n_q + N_W'(1);
          od_d    = '0;
          lon_d   = lon_q + LON_W'(lo_q);
          hin_d   = hin_q + HIN_W'(hi_q);
          vminn_d = vminn_q + VN_W'(cfg_i.vco_min);
          vmaxn_d = vmaxn_q + VN_W'(cfg_i.vco_max);
        end else if (m_q != M_LAST) begin
          m_d     = m_q + M_W'(1);
          n_d     = N_FIRST;
          od_d    = '0;
          refm_d  = refm_q + REFM_W'(cfg_i.ref_freq);
          lon_d   = LON_W'(lo_q) << 1;
          hin_d   = HIN_W'(hi_q) << 1;
          vminn_d = VN_W'(cfg_i.vco_min) << 1;
          vmaxn_d = VN_W'(cfg_i.vco_max) << 1;
        end else begin
          state_d = ST_DONE;
          found_d = 1'b0;
          word_d  = '0;
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers carry no reset; every search loads them first.
  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    n_q     <= n_d;
    od_q    <= od_d;
    refm_q  <= refm_d;
    lon_q   <= lon_d;
    hin_q   <= hin_d;
    vminn_q <= vminn_d;
    vmaxn_q <= vmaxn_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    word_q  <= word_d;
  end

  assign cand_o.n      = n_q;
  assign cand_o.od     = od_q;
  assign cand_o.ref_m  = refm_q;
  assign cand_o.lo_n   = lon_q;
  assign cand_o.hi_n   = hin_q;
  assign cand_o.vmin_n = vminn_q;
  assign cand_o.vmax_n = vmaxn_q;

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign found_o     = found_q;
  assign word_o      = word_q;

endmodule

FILE: rtl/core/pll_divider_search.sv
// PLL divider search: one candidate checked per cycle, first passing (m, n, od) wins.
// An n failing the reference ratio check is one candidate, others up to four (one per od).
// Worst case is 254 * 30 * 4 = 30480 candidates. One word is in flight at a time: the result
// waits in an output register, and the next request is taken in the cycle after it leaves.
// Async active-low reset idles the sequencer and loads 27 MHz, tol 32, VCO 200..1000 MHz.
`timescale 1ns / 1ps
module pll_divider_search
  import pds_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pds_req_if.sink   req_i,
  pds_rsp_if.source rsp_o,
  pds_cfg_if.sink   cfg_i
);

  cfg_t  cfg;
  cand_t cand;
  eval_t eval_res;
  logic  idle;
  logic  start;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  pds_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // A new request word is taken only while the sequencer is idle.
  assign req_i.ready = idle;
  assign start       = req_i.valid && idle;

  pds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .target_i    (req_i.target_freq_q4),
    .idle_o      (idle),
    .cand_o      (cand),
    .eval_i      (eval_res),
    .res_valid_o (rsp_o.valid),
    .res_ready_i (rsp_o.ready),
    .found_o     (rsp_o.found),
    .word_o      (rsp_o.divider_word)
  );

  pds_eval u_eval (
    .ref_freq_i (cfg.ref_freq),
    .cand_i     (cand),
    .eval_o     (eval_res)
  );

endmodule
